// ===== rtl/core/lmpz_pkg.sv =====
`default_nettype none

package lmpz_pkg;

  // Default geometry, handed to the top level parameters.
  localparam int DEF_IMAGE_WIDTH  = 64;
  localparam int DEF_IMAGE_HEIGHT = 64;
  localparam int DEF_LABEL_COUNT  = 16;

  // Channel limit of the summing logic.
  localparam int MAX_CHANNELS = 4;
  localparam int CH_LIMIT     = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

  localparam int SAMPLE_W  = 8;
  localparam int Z_W       = 16;
  localparam int SUM_W     = 10;
  localparam int NCH_W     = 3;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 88;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0]      peak;
    logic [Z_W-1:0]        z;
    logic [4*SAMPLE_W-1:0] samples;
  } label_entry_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak;
    logic [Z_W-1:0]      z;
  } ref_entry_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic                  oor;
    logic [Z_W-1:0]        z;
    logic [SAMPLE_W-1:0]   ref_s;
    logic [4*SAMPLE_W-1:0] samples;
    logic [NCH_W-1:0]      nch;
  } voxel_t;

  typedef struct packed {
    logic         label_we;
    logic         ref_we;
    label_entry_t label_new;
    ref_entry_t   ref_new;
  } merge_res_t;

  localparam label_entry_t LABEL_RESET = '{peak: '0, z: '1, samples: '0};
  localparam ref_entry_t   REF_RESET   = '{peak: '0, z: '1};

endpackage

`default_nettype wire

// ===== rtl/core/lmpz_ram.sv =====
`default_nettype none

module lmpz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old word when read and write hit the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/lmpz_clear.sv =====
`default_nettype none

module lmpz_clear
  import lmpz_pkg::*;
#(
  parameter longint ENTRIES = 16,
  parameter longint PIXELS  = 1,
  localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  output logic                   busy,
  output logic [ENT_AW-1:0]      addr,
  output logic                   ref_en
);

  logic              busy_r;
  logic [ENT_AW-1:0] cnt_r;

  // One entry per cycle; the pixel store is covered by the first PIXELS steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + ENT_AW'(1);
      if (cnt_r == ENT_AW'(ENTRIES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy   = busy_r;
  assign addr   = cnt_r;
  assign ref_en = busy_r && (longint'(cnt_r) < PIXELS);

endmodule

`default_nettype wire

// ===== rtl/core/lmpz_merge.sv =====
`default_nettype none

module lmpz_merge
  import lmpz_pkg::*;
(
  input  wire voxel_t       vox,
  input  wire label_entry_t label_old,
  input  wire ref_entry_t   ref_old,
  output merge_res_t        res
);

  logic [SUM_W-1:0] sum;
  logic [4*SAMPLE_W-1:0] merged;
  logic             upd;
  logic             lup;
  logic             rup;

  always_comb begin
    sum    = '0;
    merged = label_old.samples;
    for (int i = 0; i < 4; i++) begin
      if (NCH_W'(i) < vox.nch) begin
        sum = sum + SUM_W'(vox.samples[i*SAMPLE_W +: SAMPLE_W]);
        merged[i*SAMPLE_W +: SAMPLE_W] = vox.samples[i*SAMPLE_W +: SAMPLE_W];
      end
    end
    upd = !vox.oor && (vox.cmd == CMD_UPDATE);
    lup = upd && (sum > label_old.peak);
    rup = upd && (vox.ref_s > ref_old.peak);

    res.label_we  = lup;
    res.ref_we    = rup;
    res.label_new = label_old;
    res.ref_new   = ref_old;
    if (vox.oor) begin
      res.label_new = LABEL_RESET;
      res.ref_new   = REF_RESET;
    end else begin
      if (lup) begin
        res.label_new = '{peak: sum, z: vox.z, samples: merged};
      end
      if (rup) begin
        res.ref_new = '{peak: vox.ref_s, z: vox.z};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/labeled_max_projection_zbuffer.sv =====
`default_nettype none
// Pipeline: stage 1 registers an accepted input with its reads, then the output register its result.
// Throughput: one voxel or read per cycle unless the output stalls; a read-modify-write of the label
//   and pixel memories with one-deep forwarding lets the same entry be hit in consecutive cycles.
// Reset: synchronous, active low; afterwards a clearing pass writes one entry per cycle over all
//   IMAGE_WIDTH*IMAGE_HEIGHT*LABEL_COUNT entries (65536 by default), with in_tready low.

module labeled_max_projection_zbuffer
  import lmpz_pkg::*;
#(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
  parameter int LABEL_COUNT  = DEF_LABEL_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pos_x[5:0], pos_y[11:6], slice_z[27:12], mask_label[31:28], ref_sample[39:32],
  // sample_ch0[47:40], sample_ch1[55:48], sample_ch2[63:56], sample_ch3[71:64]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  wire logic                  in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // label_updated[0], ref_updated[1], ref_peak[9:2], ref_peak_z[25:10],
  // label_peak[35:26], label_peak_z[51:36], peak_ch0[59:52], peak_ch1[67:60],
  // peak_ch2[75:68], peak_ch3[83:76], zero[87:84]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // configuration: channels_in_use
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [NCH_W-1:0]      cfg_data
);

  localparam longint PIXELS  = longint'(IMAGE_WIDTH) * longint'(IMAGE_HEIGHT);
  localparam longint ENTRIES = PIXELS * longint'(LABEL_COUNT);
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LABEL_W = $bits(label_entry_t);
  localparam int REF_W   = $bits(ref_entry_t);

  // ---------------- configuration ----------------
  logic [NCH_W-1:0] chan_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= NCH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      chan_r <= cfg_data;
    end
  end

  // ---------------- clearing pass ----------------
  logic              clr_busy;
  logic [ENT_AW-1:0] clr_addr;
  logic              clr_ref_en;

  lmpz_clear #(
    .ENTRIES (ENTRIES),
    .PIXELS  (PIXELS)
  ) u_clear (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (clr_busy),
    .addr   (clr_addr),
    .ref_en (clr_ref_en)
  );

  // ---------------- stage 0: decode and issue reads ----------------
  logic [5:0]            in_x;
  logic [5:0]            in_y;
  logic [3:0]            in_lab;
  logic [31:0]           pix_full;
  logic [31:0]           ent_full;
  logic [PIX_AW-1:0]     in_pix;
  logic [ENT_AW-1:0]     in_ent;
  logic [NCH_W-1:0]      nch_eff;
  voxel_t                in_vox;
  logic                  in_accept;

  assign in_x   = in_tdata[5:0];
  assign in_y   = in_tdata[11:6];
  assign in_lab = in_tdata[31:28];

  // Address of (pixel, label): constant multiplies only.
  assign pix_full = 32'(in_y) * 32'(IMAGE_WIDTH) + 32'(in_x);
  assign ent_full = pix_full * 32'(LABEL_COUNT) + 32'(in_lab);
  assign in_pix   = pix_full[PIX_AW-1:0];
  assign in_ent   = ent_full[ENT_AW-1:0];

  // Saturate the channel count to 1 .. CH_LIMIT.
  always_comb begin
    if (chan_r == '0) begin
      nch_eff = NCH_W'(1);
    end else if (chan_r > NCH_W'(CH_LIMIT)) begin
      nch_eff = NCH_W'(CH_LIMIT);
    end else begin
      nch_eff = chan_r;
    end
  end

  assign in_vox.cmd     = cmd_t'(in_tuser);
  assign in_vox.oor     = (32'(in_x) >= 32'(IMAGE_WIDTH)) ||
                          (32'(in_y) >= 32'(IMAGE_HEIGHT)) ||
                          (32'(in_lab) >= 32'(LABEL_COUNT));
  assign in_vox.z       = in_tdata[27:12];
  assign in_vox.ref_s   = in_tdata[39:32];
  assign in_vox.samples = in_tdata[71:40];
  assign in_vox.nch     = nch_eff;

  // ---------------- stage 1: modify and write back ----------------
  logic              s1_valid_r;
  voxel_t            s1_vox_r;
  logic [PIX_AW-1:0] s1_pix_r;
  logic [ENT_AW-1:0] s1_ent_r;
  logic              s1_adv;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  label_entry_t label_rd;
  ref_entry_t   ref_rd;
  label_entry_t label_old;
  ref_entry_t   ref_old;
  merge_res_t   mres;
  logic         label_we_s1;
  logic         ref_we_s1;

  // Forwarding of the write that landed on the edge the read was issued.
  logic         fwd_l_hit_r;
  logic         fwd_r_hit_r;
  label_entry_t fwd_l_data_r;
  ref_entry_t   fwd_r_data_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_accept = in_tvalid && in_tready;

  assign label_old = fwd_l_hit_r ? fwd_l_data_r : label_rd;
  assign ref_old   = fwd_r_hit_r ? fwd_r_data_r : ref_rd;

  lmpz_merge u_merge (
    .vox       (s1_vox_r),
    .label_old (label_old),
    .ref_old   (ref_old),
    .res       (mres)
  );

  assign label_we_s1 = s1_adv && mres.label_we;
  assign ref_we_s1   = s1_adv && mres.ref_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_l_hit_r <= 1'b0;
      fwd_r_hit_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r  <= 1'b1;
        fwd_l_hit_r <= label_we_s1 && (s1_ent_r == in_ent);
        fwd_r_hit_r <= ref_we_s1 && (s1_pix_r == in_pix);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_vox_r     <= in_vox;
      s1_pix_r     <= in_pix;
      s1_ent_r     <= in_ent;
      fwd_l_data_r <= mres.label_new;
      fwd_r_data_r <= mres.ref_new;
    end
  end

  // ---------------- memories ----------------
  logic              lm_we;
  logic [ENT_AW-1:0] lm_waddr;
  label_entry_t      lm_wdata;
  logic              rm_we;
  logic [PIX_AW-1:0] rm_waddr;
  ref_entry_t        rm_wdata;

  assign lm_we    = clr_busy || label_we_s1;
  assign lm_waddr = clr_busy ? clr_addr : s1_ent_r;
  assign lm_wdata = clr_busy ? LABEL_RESET : mres.label_new;
  assign rm_we    = clr_ref_en || ref_we_s1;
  assign rm_waddr = clr_busy ? clr_addr[PIX_AW-1:0] : s1_pix_r;
  assign rm_wdata = clr_busy ? REF_RESET : mres.ref_new;

  lmpz_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (int'(ENTRIES))
  ) u_label_mem (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .re    (in_accept),
    .raddr (in_ent),
    .rdata (label_rd)
  );

  lmpz_ram #(
    .WIDTH (REF_W),
    .DEPTH (int'(PIXELS))
  ) u_ref_mem (
    .clk   (clk),
    .we    (rm_we),
    .waddr (rm_waddr),
    .wdata (rm_wdata),
    .re    (in_accept),
    .raddr (in_pix),
    .rdata (ref_rd)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {4'b0000,
                     mres.label_new.samples,
                     mres.label_new.z,
                     mres.label_new.peak,
                     mres.ref_new.z,
                     mres.ref_new.peak,
                     mres.ref_we,
                     mres.label_we};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("input accepted during clearing pass");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !(label_we_s1 || ref_we_s1))
    else $error("update write collides with clearing pass");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept ##1 fwd_l_hit_r |-> $past(label_we_s1))
    else $error("label forward without preceding write");

  a_read_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_vox_r.cmd == CMD_READ)) |-> !(mres.label_we || mres.ref_we))
    else $error("read transaction modifies a store");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && !$past(s1_adv)))
    else $error("stage 1 advanced into a stalled output");

endmodule

`default_nettype wire
